@@ src/tst_pkg.sv @@
package tst_pkg;

  // Default number of fractional bits of every fixed-point quantity.
  localparam int FRAC_BITS_DEF = 16;

  // Datapath widths.
  localparam int DW = 32;   // magnitude of one coordinate difference
  localparam int SW = 66;   // sum of the three squares
  localparam int RW = 33;   // square root of a sum of squares
  localparam int QW = 64;   // divider operand and quotient width

  // Configuration register indexes and reset values.
  localparam logic CFG_VEL = 1'b0;
  localparam logic CFG_ACC = 1'b1;
  localparam logic [31:0] VEL_RESET = 32'd262144;
  localparam logic [31:0] ACC_RESET = 32'd262144;

  // Saturated segment time.
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  // One segment request: absolute coordinate differences.
  typedef struct packed {
    logic [DW-1:0] dx;
    logic [DW-1:0] dy;
    logic [DW-1:0] dz;
  } seg_req_t;

  // Square root unit command and response.
  typedef struct packed {
    logic          go;
    logic [SW-1:0] rad;
  } sqrt_cmd_t;

  typedef struct packed {
    logic          done;
    logic [RW-1:0] root;
  } sqrt_rsp_t;

  // Divider command and response.
  typedef struct packed {
    logic          go;
    logic          long_run;
    logic [QW-1:0] rem0;
    logic [QW-1:0] lb;
    logic [QW-1:0] den;
  } div_cmd_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quot;
  } div_rsp_t;

endpackage

@@ src/tst_queue.sv @@
module tst_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tst_pkg::seg_req_t  push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output tst_pkg::seg_req_t  pop_data
);

  tst_pkg::seg_req_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !full) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop && not_empty) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if ((push && !full) && !(pop && not_empty)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!(push && !full) && (pop && not_empty)) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ src/tst_front.sv @@
module tst_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       in_pos_x,
  input  logic [31:0]       in_pos_y,
  input  logic [31:0]       in_pos_z,
  input  logic              in_path_start,
  output logic              push,
  output tst_pkg::seg_req_t push_data,
  input  logic              q_full
);

  logic [31:0] prev_x_r, prev_y_r, prev_z_r;
  logic        have_prev_r;
  logic        accept;
  logic [32:0] diff_x, diff_y, diff_z;
  logic [32:0] mag_x, mag_y, mag_z;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Signed differences to the previous point, then their magnitudes.
  assign diff_x = {in_pos_x[31], in_pos_x} - {prev_x_r[31], prev_x_r};
  assign diff_y = {in_pos_y[31], in_pos_y} - {prev_y_r[31], prev_y_r};
  assign diff_z = {in_pos_z[31], in_pos_z} - {prev_z_r[31], prev_z_r};
  assign mag_x  = diff_x[32] ? (33'd0 - diff_x) : diff_x;
  assign mag_y  = diff_y[32] ? (33'd0 - diff_y) : diff_y;
  assign mag_z  = diff_z[32] ? (33'd0 - diff_z) : diff_z;

  // A point opens a segment only when a previous point of its path is held.
  assign push         = accept && have_prev_r && !in_path_start;
  assign push_data.dx = mag_x[31:0];
  assign push_data.dy = mag_y[31:0];
  assign push_data.dz = mag_z[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= 32'd0;
      prev_y_r    <= 32'd0;
      prev_z_r    <= 32'd0;
      have_prev_r <= 1'b0;
    end else if (accept) begin
      prev_x_r    <= in_pos_x;
      prev_y_r    <= in_pos_y;
      prev_z_r    <= in_pos_z;
      have_prev_r <= 1'b1;
    end
  end

endmodule

@@ src/tst_sqrt.sv @@
module tst_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  tst_pkg::sqrt_cmd_t cmd,
  output tst_pkg::sqrt_rsp_t rsp
);

  localparam logic [5:0] LAST_STEP = 6'(tst_pkg::RW - 1);

  logic [tst_pkg::SW-1:0] rad_r;
  logic [35:0]            rem_r;
  logic [tst_pkg::RW-1:0] root_r;
  logic [5:0]             cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic [35:0]            rem_sh;
  logic [35:0]            trial;
  logic                   fits;

  // One root bit per cycle: bring down two radicand bits and try 4r+1.
  assign rem_sh = {rem_r[33:0], rad_r[tst_pkg::SW-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  assign rsp.done = done_r;
  assign rsp.root = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (cmd.go) begin
        busy_r <= 1'b1;
        cnt_r  <= LAST_STEP;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      rad_r  <= cmd.rad;
      rem_r  <= 36'd0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[tst_pkg::SW-3:0], 2'b00};
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[tst_pkg::RW-2:0], fits};
    end
  end

endmodule

@@ src/tst_div.sv @@
module tst_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tst_pkg::div_cmd_t cmd,
  output tst_pkg::div_rsp_t rsp
);

  localparam int W = tst_pkg::QW;

  logic [W-1:0] rem_r, lb_r, quot_r, den_r;
  logic [5:0]   cnt_r;
  logic         busy_r;
  logic         done_r;
  logic [W:0]   trial;
  logic         fits;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem_r, lb_r[W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (cmd.go) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.long_run ? 6'd63 : 6'd31;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      rem_r  <= cmd.rem0;
      lb_r   <= cmd.lb;
      den_r  <= cmd.den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? W'(trial - {1'b0, den_r}) : trial[W-1:0];
      lb_r   <= {lb_r[W-2:0], 1'b0};
      quot_r <= {quot_r[W-2:0], fits};
    end
  end

endmodule

@@ src/tst_back.sv @@
module tst_back #(
  parameter int FRAC_BITS = tst_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  tst_pkg::seg_req_t  q_data,
  output logic               q_pop,
  input  logic [31:0]        vel,
  input  logic [31:0]        acc,
  output tst_pkg::sqrt_cmd_t sqrt_cmd,
  input  tst_pkg::sqrt_rsp_t sqrt_rsp,
  output tst_pkg::div_cmd_t  div_cmd,
  input  tst_pkg::div_rsp_t  div_rsp,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_segment_time,
  output logic               out_is_triangular
);

  localparam int QW = tst_pkg::QW;
  localparam int SW = tst_pkg::SW;
  localparam int RW = tst_pkg::RW;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SQ     = 8'b0000_0010,
    S_ROOT   = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_DECIDE = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_TROOT  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  tst_pkg::seg_req_t  req_r;
  logic [1:0]         sel_r;
  logic [SW-1:0]      acc_sum_r;
  logic [63:0]        prod_r;
  logic [31:0]        mul_a, mul_b;
  logic [RW-1:0]      dist_r;
  logic [64:0]        da_r;
  logic [63:0]        vv_r, av_r;
  logic [QW-1:0]      q_r;
  logic [31:0]        time_r;
  logic               tri_r;
  logic               root_go_r, div_go_r;
  logic               div_long_r;
  logic [QW-1:0]      div_rem0_r, div_lb_r, div_den_r;
  logic               out_valid_r;
  logic [31:0]        out_time_r;
  logic               out_tri_r;
  logic               out_free;
  logic [127:0]       tri_num;
  logic [65:0]        trap_n;
  logic [127:0]       trap_num;
  logic               is_tri;
  logic               tri_sat, trap_sat;

  assign q_pop    = (state_r == S_IDLE) && q_not_empty;
  assign out_free = !out_valid_r || !out_stall;

  // Shared 32x32 multiplier with a registered product.
  always_comb begin
    mul_a = req_r.dz;
    mul_b = req_r.dz;
    if (state_r == S_SQ) begin
      case (sel_r)
        2'd0:    begin mul_a = req_r.dx; mul_b = req_r.dx; end
        2'd1:    begin mul_a = req_r.dy; mul_b = req_r.dy; end
        default: begin mul_a = req_r.dz; mul_b = req_r.dz; end
      endcase
    end else begin
      case (sel_r)
        2'd0:    begin mul_a = dist_r[31:0]; mul_b = acc; end
        2'd1:    begin mul_a = vel; mul_b = vel; end
        default: begin mul_a = acc; mul_b = vel; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  // Triangular: floor(D * 2^(2F+2) / a). Trapezoidal: floor((vv + Da) * 2^F / av).
  assign is_tri   = (da_r < {1'b0, vv_r});
  assign tri_num  = 128'(dist_r) << (2 * FRAC_BITS + 2);
  assign trap_n   = 66'(da_r) + 66'(vv_r);
  assign trap_num = 128'(trap_n) << (FRAC_BITS + 32);
  assign tri_sat  = (tri_num[127:64] >= {32'd0, acc});
  assign trap_sat = (trap_num[127:64] >= av_r);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (q_not_empty) state_nxt = S_SQ;
      S_SQ:     if (sel_r == 2'd3) state_nxt = S_ROOT;
      S_ROOT:   if (sqrt_rsp.done) state_nxt = S_MUL;
      S_MUL:    if (sel_r == 2'd3) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (acc == 32'd0 || vel == 32'd0) begin
          state_nxt = S_OUT;
        end else if (is_tri) begin
          state_nxt = tri_sat ? S_OUT : S_DIV;
        end else begin
          state_nxt = trap_sat ? S_OUT : S_DIV;
        end
      end
      S_DIV:    if (div_rsp.done) state_nxt = tri_r ? S_TROOT : S_OUT;
      S_TROOT:  if (sqrt_rsp.done) state_nxt = S_OUT;
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      root_go_r   <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      root_go_r <= ((state_r == S_SQ) && (sel_r == 2'd3)) ||
                   ((state_r == S_DIV) && div_rsp.done && tri_r);
      div_go_r  <= (state_r == S_DECIDE) && (state_nxt == S_DIV);
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        req_r     <= q_data;
        acc_sum_r <= '0;
        sel_r     <= 2'd0;
      end
      S_SQ: begin
        sel_r <= sel_r + 2'd1;
        if (sel_r != 2'd0) begin
          acc_sum_r <= acc_sum_r + SW'(prod_r);
        end
      end
      S_ROOT: begin
        sel_r <= 2'd0;
        if (sqrt_rsp.done) begin
          dist_r <= sqrt_rsp.root;
        end
      end
      S_MUL: begin
        sel_r <= sel_r + 2'd1;
        case (sel_r)
          2'd1:    da_r <= 65'(prod_r) + (dist_r[RW-1] ? {1'b0, acc, 32'd0} : 65'd0);
          2'd2:    vv_r <= prod_r;
          2'd3:    av_r <= prod_r;
          default: ;
        endcase
      end
      S_DECIDE: begin
        if (acc == 32'd0) begin
          time_r <= tst_pkg::TIME_MAX;
          tri_r  <= 1'b1;
        end else if (vel == 32'd0) begin
          time_r <= tst_pkg::TIME_MAX;
          tri_r  <= 1'b0;
        end else if (is_tri) begin
          time_r     <= tst_pkg::TIME_MAX;
          tri_r      <= 1'b1;
          div_long_r <= 1'b1;
          div_rem0_r <= tri_num[127:64];
          div_lb_r   <= tri_num[63:0];
          div_den_r  <= {32'd0, acc};
        end else begin
          time_r     <= tst_pkg::TIME_MAX;
          tri_r      <= 1'b0;
          div_long_r <= 1'b0;
          div_rem0_r <= trap_num[127:64];
          div_lb_r   <= trap_num[63:0];
          div_den_r  <= av_r;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          q_r    <= div_rsp.quot;
          time_r <= div_rsp.quot[31:0];
        end
      end
      S_TROOT: begin
        if (sqrt_rsp.done) begin
          time_r <= sqrt_rsp.root[31:0];
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_time_r <= time_r;
          out_tri_r  <= tri_r;
        end
      end
      default: ;
    endcase
  end

  // Commands to the iterative units.
  assign sqrt_cmd.go  = root_go_r;
  assign sqrt_cmd.rad = (state_r == S_TROOT) ? SW'(q_r) : acc_sum_r;

  assign div_cmd.go       = div_go_r;
  assign div_cmd.long_run = div_long_r;
  assign div_cmd.rem0     = div_rem0_r;
  assign div_cmd.lb       = div_lb_r;
  assign div_cmd.den      = div_den_r;

  assign out_valid         = out_valid_r;
  assign out_segment_time  = out_time_r;
  assign out_is_triangular = out_tri_r;

  // A new result is only loaded from the output state.
  a_out_from_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result loaded outside the output state");

  // Root starts only on entry to one of the root states.
  a_root_go: assert property (@(posedge clk) disable iff (!rst_n)
    root_go_r |-> (state_r == S_ROOT || state_r == S_TROOT))
    else $error("square root started outside a root state");

  // Divider starts only while waiting for its quotient.
  a_div_go: assert property (@(posedge clk) disable iff (!rst_n)
    div_go_r |-> (state_r == S_DIV) && $past(state_r == S_DECIDE))
    else $error("divider started out of sequence");

  // A triangular result with nonzero acceleration really is below threshold.
  a_tri_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && tri_r && acc != 32'd0) |-> (da_r < {1'b0, vv_r}))
    else $error("triangular flag disagrees with threshold test");

endmodule

@@ src/trapezoid_segment_time.sv @@
// Segment time allocator for a trapezoidal velocity profile. Waypoints come in
// as signed fixed point with FRAC_BITS fractional bits; the first point of a
// path (path_start set, or none held yet) gives no result, every later point
// gives one segment time in unsigned fixed point, saturating at all ones, plus
// a flag telling whether cruise velocity is reached. A front stage forms the
// coordinate differences and queues them two deep, so points keep coming in
// while the back end works. The back end handles one segment at a time through
// one shared 32x32 multiplier, a bit-serial square root unit (33 steps) and a
// bit-serial divider (32 steps for a trapezoidal segment, 64 for a
// triangular one). A saturated or degenerate segment skips the divider. From
// the pop of the queue a segment occupies the back end until its result is
// handed on, also while the result is stalled.
// Configuration (velocity at index 0, acceleration at index 1) is always ready
// and must be written only while the block is idle.
module trapezoid_segment_time #(
  parameter int FRAC_BITS = tst_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic        in_path_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_segment_time,
  output logic        out_is_triangular,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]        vel_r, acc_r;
  logic               push, q_full, q_pop, q_not_empty;
  tst_pkg::seg_req_t  push_data, q_data;
  tst_pkg::sqrt_cmd_t sqrt_cmd;
  tst_pkg::sqrt_rsp_t sqrt_rsp;
  tst_pkg::div_cmd_t  div_cmd;
  tst_pkg::div_rsp_t  div_rsp;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r <= tst_pkg::VEL_RESET;
      acc_r <= tst_pkg::ACC_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tst_pkg::CFG_VEL: vel_r <= cfg_data;
        tst_pkg::CFG_ACC: acc_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  tst_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_path_start (in_path_start),
    .push          (push),
    .push_data     (push_data),
    .q_full        (q_full)
  );

  tst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  tst_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (sqrt_cmd),
    .rsp   (sqrt_rsp)
  );

  tst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .rsp   (div_rsp)
  );

  tst_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .vel               (vel_r),
    .acc               (acc_r),
    .sqrt_cmd          (sqrt_cmd),
    .sqrt_rsp          (sqrt_rsp),
    .div_cmd           (div_cmd),
    .div_rsp           (div_rsp),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_segment_time  (out_segment_time),
    .out_is_triangular (out_is_triangular)
  );

endmodule
